// ===== hw/rtl/mcd_pkg.sv =====
package mcd_pkg;

   localparam int unsigned MCD_QUEUE_DEPTH = 2;

   localparam int unsigned MONTH_W    = 4;
   localparam int unsigned YEAR_W     = 14;
   localparam int unsigned DAY_W      = 5;
   localparam int unsigned WEEKDAY_W  = 3;
   localparam int unsigned ROW_W      = 3;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;

   // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for x <= 9999
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int unsigned DIV100_SHIFT = 19;
   // floor(x / 7) = (x * DIV7_MUL) >> DIV7_SHIFT for x < 16384
   localparam logic [15:0] DIV7_MUL     = 16'd37450;
   localparam int unsigned DIV7_SHIFT   = 18;

   localparam logic [WEEKDAY_W-1:0] SATURDAY = 3'd6;

   // one month job handed from the front end to the day sequencer
   typedef struct packed {
      logic                 invalid;
      logic [WEEKDAY_W-1:0] first_wd;
      logic [DAY_W-1:0]     month_len;
   } cal_job_type;

   // floor(31 * sm / 12) for the shifted month (March = 1)
   function automatic logic [DAY_W-1:0] shifted_month_offset(input logic [MONTH_W-1:0] sm);
      logic [DAY_W-1:0] res;
      unique case (sm)
         4'd1:    res = 5'd2;
         4'd2:    res = 5'd5;
         4'd3:    res = 5'd7;
         4'd4:    res = 5'd10;
         4'd5:    res = 5'd12;
         4'd6:    res = 5'd15;
         4'd7:    res = 5'd18;
         4'd8:    res = 5'd20;
         4'd9:    res = 5'd23;
         4'd10:   res = 5'd25;
         4'd11:   res = 5'd28;
         4'd12:   res = 5'd31;
         default: res = 5'd0;
      endcase
      return res;
   endfunction

   // length of a month other than February
   function automatic logic [DAY_W-1:0] plain_month_len(input logic [MONTH_W-1:0] mon);
      logic [DAY_W-1:0] res;
      unique case (mon)
         4'd4, 4'd6, 4'd9, 4'd11: res = 5'd30;
         default:                 res = 5'd31;
      endcase
      return res;
   endfunction

endpackage

// ===== hw/rtl/mcd_front.sv =====
module mcd_front
   import mcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MONTH_W-1:0]  req_month,
   input  logic [YEAR_W-1:0]   req_year,
   output logic                job_valid,
   input  logic                job_ready,
   output cal_job_type         job
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_SUM  = 5'b00100,
      ST_MOD  = 5'b01000,
      ST_PUSH = 5'b10000
   } front_state_type;

   front_state_type state_ff, state_in;

   logic [MONTH_W-1:0] mon_ff;
   logic [YEAR_W-1:0]  yr_ff;
   logic               bad_ff;
   logic [YEAR_W-1:0]  sy_ff;
   logic [MONTH_W-1:0] sm_ff;
   logic [6:0]         q100sy_ff;
   logic [6:0]         q100yr_ff;
   logic [YEAR_W-1:0]  sum_ff;
   logic [DAY_W-1:0]   len_ff;
   logic [11:0]        q7_ff;

   logic               req_bad;
   logic               jan_feb;
   logic [26:0]        prod_sy;
   logic [26:0]        prod_yr;
   logic [YEAR_W:0]    sum_calc;
   logic [13:0]        hundreds;
   logic               leap;
   logic [DAY_W-1:0]   len_calc;
   logic [29:0]        prod_sum;
   logic [14:0]        q7_times7;
   logic [YEAR_W-1:0]  rem7;

   assign req_ready = (state_ff == ST_IDLE);
   assign job_valid = (state_ff == ST_PUSH);

   assign req_bad = (req_month < MONTH_JAN) || (req_month > MONTH_DEC) ||
                    (req_year < YEAR_MIN) || (req_year > YEAR_MAX);
   assign jan_feb = (req_month <= MONTH_FEB);

   assign prod_sy = {13'd0, sy_ff} * {14'd0, DIV100_MUL};
   assign prod_yr = {13'd0, yr_ff} * {14'd0, DIV100_MUL};

   assign sum_calc = 15'd1 + {1'b0, sy_ff} + {3'b0, sy_ff[YEAR_W-1:2]}
                     - {8'd0, q100sy_ff} + {10'd0, q100sy_ff[6:2]}
                     + {10'd0, shifted_month_offset(sm_ff)};

   assign hundreds = {7'd0, q100yr_ff} * 14'd100;
   assign leap = ((yr_ff[1:0] == 2'b00) && (hundreds != yr_ff)) ||
                 ((hundreds == yr_ff) && (q100yr_ff[1:0] == 2'b00));
   assign len_calc = (mon_ff == MONTH_FEB) ? (leap ? 5'd29 : 5'd28) : plain_month_len(mon_ff);

   assign prod_sum = {16'd0, sum_ff} * {14'd0, DIV7_MUL};
   assign q7_times7 = {3'd0, q7_ff} * 15'd7;
   assign rem7 = sum_ff - q7_times7[YEAR_W-1:0];

   always_comb begin
      job.invalid   = bad_ff;
      job.first_wd  = rem7[WEEKDAY_W-1:0];
      job.month_len = len_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_MOD;
         ST_MOD:  state_in = ST_PUSH;
         ST_PUSH: if (job_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         mon_ff <= req_month;
         yr_ff  <= req_year;
         bad_ff <= req_bad;
         sy_ff  <= req_year - {13'd0, jan_feb};
         sm_ff  <= jan_feb ? (req_month + 4'd10) : (req_month - 4'd2);
      end
      if (state_ff == ST_MUL) begin
         q100sy_ff <= prod_sy[DIV100_SHIFT +: 7];
         q100yr_ff <= prod_yr[DIV100_SHIFT +: 7];
      end
      if (state_ff == ST_SUM) begin
         sum_ff <= sum_calc[YEAR_W-1:0];
         len_ff <= len_calc;
      end
      if (state_ff == ST_MOD) begin
         q7_ff <= prod_sum[DIV7_SHIFT +: 12];
      end
   end

endmodule

// ===== hw/rtl/mcd_queue.sv =====
module mcd_queue
   import mcd_pkg::*;
#(
   parameter int unsigned DEPTH = MCD_QUEUE_DEPTH
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  cal_job_type push_job,
   output logic        pop_valid,
   input  logic        pop_ready,
   output cal_job_type pop_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cal_job_type      slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// ===== hw/rtl/mcd_back.sv =====
module mcd_back
   import mcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  cal_job_type          job,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DAY_W-1:0]     rsp_day_number,
   output logic [WEEKDAY_W-1:0] rsp_weekday,
   output logic [ROW_W-1:0]     rsp_week_row,
   output logic                 rsp_last_day,
   output logic                 rsp_invalid
);

   logic                 busy_ff;
   logic [DAY_W-1:0]     len_ff;
   logic                 rsp_valid_ff;
   logic [DAY_W-1:0]     day_ff;
   logic [WEEKDAY_W-1:0] col_ff;
   logic [ROW_W-1:0]     row_ff;
   logic                 last_ff;
   logic                 inv_ff;

   logic                 advance;
   logic [DAY_W-1:0]     next_day;
   logic                 wrap;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign job_ready = advance && !busy_ff;
   assign next_day  = day_ff + 1'b1;
   assign wrap      = (col_ff == SATURDAY);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_day_number = day_ff;
   assign rsp_weekday    = col_ff;
   assign rsp_week_row   = row_ff;
   assign rsp_last_day   = last_ff;
   assign rsp_invalid    = inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         if (busy_ff) begin
            rsp_valid_ff <= 1'b1;
            if (next_day == len_ff) busy_ff <= 1'b0;
         end else if (job_valid) begin
            rsp_valid_ff <= 1'b1;
            busy_ff      <= !job.invalid;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (busy_ff) begin
            day_ff  <= next_day;
            col_ff  <= wrap ? '0 : col_ff + 1'b1;
            row_ff  <= wrap ? row_ff + 1'b1 : row_ff;
            last_ff <= (next_day == len_ff);
            inv_ff  <= 1'b0;
         end else if (job_valid) begin
            len_ff  <= job.month_len;
            inv_ff  <= job.invalid;
            last_ff <= job.invalid;
            day_ff  <= job.invalid ? '0 : DAY_W'(1);
            col_ff  <= job.invalid ? '0 : job.first_wd;
            row_ff  <= '0;
         end
      end
   end

endmodule

// ===== hw/rtl/month_calendar_day_generator_core.sv =====
// Gregorian month calendar day generator. Each request names a month (1..12) and a year
// (1..9999); the block answers with one response per day of that month, in order, carrying
// the day number, its weekday column (0 = Sunday) and its row in a Sunday-first month grid,
// with rsp_last_day set on the final day. A month or year out of range gives one response
// with rsp_invalid and rsp_last_day set and all other fields zero. The front end takes a
// request through capture, divide by 100, weekday sum and month length, divide by 7 and
// hand-off, then pushes a job into a short queue; the day sequencer drains jobs and emits
// one response per cycle while rsp_ready is high, so a month yields one response per day
// (28..31 of them, one for an invalid request). The slower side sets the sustained rate:
// the sequencer for valid months, the front end for a run of invalid ones. The front end
// works on the next request while days of the previous one still stream out. No
// configuration and no state beyond the pipeline; reset only empties it.
module month_calendar_day_generator_core
   import mcd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = MCD_QUEUE_DEPTH
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [MONTH_W-1:0]   req_month,
   input  logic [YEAR_W-1:0]    req_year,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DAY_W-1:0]     rsp_day_number,
   output logic [WEEKDAY_W-1:0] rsp_weekday,
   output logic [ROW_W-1:0]     rsp_week_row,
   output logic                 rsp_last_day,
   output logic                 rsp_invalid
);

   // front end to queue
   logic        push_valid, push_ready;
   cal_job_type push_job;
   // queue to day sequencer
   logic        pop_valid, pop_ready;
   cal_job_type pop_job;

   // classify the request: range check, first weekday, month length
   mcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_month (req_month),
      .req_year  (req_year),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .job       (push_job)
   );

   // hold finished jobs so the front end can run ahead of the sequencer
   mcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // advance through the days of each job, one response per cycle while rsp_ready is high
   mcd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (pop_valid),
      .job_ready      (pop_ready),
      .job            (pop_job),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_day_number (rsp_day_number),
      .rsp_weekday    (rsp_weekday),
      .rsp_week_row   (rsp_week_row),
      .rsp_last_day   (rsp_last_day),
      .rsp_invalid    (rsp_invalid)
   );

endmodule
